FILE: sv/dsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared widths, constants and types of the divisible subarray counter.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int VALUE_W    = 20;
  localparam int RES_W      = 16;
  localparam int DIV_W      = 17;
  localparam int DIVIDEND_W = 21;
  localparam int PAIR_W     = 25;
  localparam int BEST_W     = 17;
  localparam int TAG_W      = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [PAIR_W-1:0] PAIR_MOD = PAIR_W'(20091101);
  localparam logic [BEST_W-1:0] SAT17    = '1;
  localparam logic [DIV_W-1:0]  MAX_K    = DIV_W'(65536);

  // One accepted input transaction after decoding.
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] value;
    logic               last;
  } cmd_t;

  // Status from the back end to the front end.
  typedef struct packed {
    logic clearing;
  } back_status_t;

  // One residue store entry; an entry counts only if its tag is current.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [BEST_W-1:0] count;
    logic [BEST_W-1:0] best;
  } entry_t;

  // Divisor zero acts as one; anything above the table size is clamped.
  function automatic logic [DIV_W-1:0] eff_divisor(input logic [DIV_W-1:0] k);
    logic [DIV_W-1:0] r;
    r = k;
    if (k == '0) begin
      r = DIV_W'(1);
    end else if (k > MAX_K) begin
      r = MAX_K;
    end
    return r;
  endfunction

endpackage

FILE: sv/dsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_front
// Input stage: takes stream transactions, decodes them into commands and
// hands them to the command queue. Holds off while the stores are cleared.
// ----------------------------------------------------------------------------
module dsc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,
  input  logic                  s_axis_tlast,
  input  logic                  s_axis_tuser,
  input  dsc_pkg::back_status_t status,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output dsc_pkg::cmd_t         cmd
);
  import dsc_pkg::*;

  logic hold_valid;
  cmd_t hold;

  assign s_axis_tready = !status.clearing && (!hold_valid || cmd_ready);
  assign cmd_valid     = hold_valid;
  assign cmd           = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      hold_valid <= 1'b1;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      hold.start <= s_axis_tuser;
      hold.value <= s_axis_tdata[VALUE_W-1:0];
      hold.last  <= s_axis_tlast;
    end
  end

endmodule

FILE: sv/dsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dsc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dsc_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output dsc_pkg::cmd_t out_cmd
);
  import dsc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != (PTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

FILE: sv/dsc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_divider
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module dsc_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [dsc_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [dsc_pkg::DIV_W-1:0]        divisor,
  output logic                             done,
  output logic [dsc_pkg::RES_W-1:0]        remainder
);
  import dsc_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic [CNT_W-1:0]      step;
  logic [DIVIDEND_W-1:0] dvd;
  logic [RES_W-1:0]      rem;
  logic [DIV_W-1:0]      shifted;
  logic [DIV_W-1:0]      diff;

  // The remainder stays below the divisor, so the shifted value is below twice it.
  assign shifted   = {rem, dvd[DIVIDEND_W-1]};
  assign diff      = shifted - divisor;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == CNT_W'(DIVIDEND_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIVIDEND_W-2:0], 1'b0};
      if (shifted >= divisor) begin
        rem <= diff[RES_W-1:0];
      end else begin
        rem <= shifted[RES_W-1:0];
      end
    end
  end

endmodule

FILE: sv/dsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_back
// Back end: reduces the prefix sum, updates the residue store and produces
// the running pair count and disjoint count into an output register.
// ----------------------------------------------------------------------------
module dsc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [dsc_pkg::DIV_W-1:0]   cfg_wr_data,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  dsc_pkg::cmd_t               cmd,
  output dsc_pkg::back_status_t       status,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata,
  output logic                        m_axis_tlast
);
  import dsc_pkg::*;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_SEED    = 3'd2;
  localparam logic [2:0] ST_DIVGO   = 3'd3;
  localparam logic [2:0] ST_DIVWAIT = 3'd4;
  localparam logic [2:0] ST_READ    = 3'd5;
  localparam logic [2:0] ST_CALC    = 3'd6;

  logic [2:0]        state;
  logic [RES_W-1:0]  clr_addr;
  logic              seed_pending;
  logic [TAG_W-1:0]  gen;
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W-1:0]  k_cur;
  cmd_t              cur;
  logic [RES_W-1:0]  run_res;
  logic [RES_W-1:0]  res;
  logic [PAIR_W-1:0] pairs;
  logic [BEST_W-1:0] best;

  entry_t            mem [2**RES_W];
  entry_t            rdata;
  logic              mem_we;
  logic              mem_rd;
  logic [RES_W-1:0]  mem_addr;
  entry_t            wdata;

  logic                  div_start;
  logic                  div_done;
  logic [RES_W-1:0]      div_rem;
  logic [DIVIDEND_W-1:0] dividend;

  logic              out_valid;
  logic              out_free;
  logic              seen;
  logic [BEST_W-1:0] cnt;
  logic [BEST_W-1:0] bst;
  logic [BEST_W-1:0] cnt_inc;
  logic [BEST_W-1:0] cand;
  logic [BEST_W-1:0] best_next;
  logic [PAIR_W-1:0] pair_sum;
  logic [PAIR_W-1:0] pairs_next;

  assign cmd_ready       = (state == ST_IDLE);
  assign status.clearing = (state == ST_CLEAR);
  assign out_free        = !out_valid || m_axis_tready;
  assign m_axis_tvalid   = out_valid;
  assign div_start       = (state == ST_DIVGO);
  assign dividend        = DIVIDEND_W'(run_res) + DIVIDEND_W'(cur.value);

  dsc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (k_cur),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Entry update for the residue just found.
  always_comb begin
    seen      = (rdata.tag == gen);
    cnt       = seen ? rdata.count : '0;
    bst       = seen ? rdata.best : '0;
    cnt_inc   = (cnt == SAT17) ? SAT17 : cnt + 1'b1;
    cand      = (bst == SAT17) ? SAT17 : bst + 1'b1;
    best_next = (seen && (cand > best)) ? cand : best;
    // Both terms are below the modulus, so one subtraction is enough.
    pair_sum  = pairs + PAIR_W'(cnt);
    pairs_next = (pair_sum >= PAIR_MOD) ? pair_sum - PAIR_MOD : pair_sum;
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_rd   = 1'b0;
    mem_addr = res;
    wdata    = '0;
    case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      ST_SEED: begin
        mem_we      = 1'b1;
        mem_addr    = '0;
        wdata.tag   = gen;
        wdata.count = BEST_W'(1);
      end
      ST_READ: begin
        mem_rd = 1'b1;
      end
      ST_CALC: begin
        mem_we      = out_free;
        wdata.tag   = gen;
        wdata.count = cnt_inc;
        wdata.best  = best_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= DIV_W'(1);
    end else if (cfg_wr_en) begin
      divisor <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      seed_pending <= 1'b0;
      gen          <= TAG_W'(1);
      run_res      <= '0;
      pairs        <= '0;
      best         <= '0;
      out_valid    <= 1'b0;
    end else begin
      // A result taken in the same cycle as a new one is loaded stays valid.
      if (out_valid && m_axis_tready && !((state == ST_CALC) && out_free)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            gen          <= TAG_W'(1);
            seed_pending <= 1'b0;
            state        <= seed_pending ? ST_SEED : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.start) begin
              run_res <= '0;
              pairs   <= '0;
              best    <= '0;
              // A new case takes a fresh tag; when the tags run out the
              // whole store is swept back to the unwritten tag first.
              if (gen == '1) begin
                seed_pending <= 1'b1;
                clr_addr     <= '0;
                state        <= ST_CLEAR;
              end else begin
                gen   <= gen + 1'b1;
                state <= ST_SEED;
              end
            end else begin
              state <= ST_DIVGO;
            end
          end
        end
        ST_SEED: begin
          state <= ST_DIVGO;
        end
        ST_DIVGO: begin
          state <= ST_DIVWAIT;
        end
        ST_DIVWAIT: begin
          if (div_done) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (out_free) begin
            pairs     <= pairs_next;
            best      <= best_next;
            run_res   <= res;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && cmd_valid) begin
      cur   <= cmd;
      k_cur <= eff_divisor(divisor);
    end
    if ((state == ST_DIVWAIT) && div_done) begin
      res <= div_rem;
    end
    if ((state == ST_CALC) && out_free) begin
      m_axis_tdata <= {6'b0, best_next, pairs_next};
      m_axis_tlast <= cur.last;
    end
  end

endmodule

FILE: sv/divisible_subarray_counter.sv
`timescale 1ns / 1ps
// The 21-step remainder unit serves one item at a time; an item that starts a case
// passes through a seed state first. The back end takes a new item only after the
// last one's result is loaded into the output register; a four-entry queue buffers input.
// Reset clears all control state and then sweeps the 65536-entry residue store
// with input held off; every 255th case start repeats the sweep.
// ----------------------------------------------------------------------------
// divisible_subarray_counter
// Counts subarrays whose sum is divisible by a configured divisor, and the
// most disjoint such subarrays, as running results per streamed value.
// ----------------------------------------------------------------------------
module divisible_subarray_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,   // divisor
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [19:0] box_value, rest zero
  input  logic        s_axis_tlast,  // end_case
  input  logic        s_axis_tuser,  // start_case
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [24:0] pair_count, [41:25] max_disjoint
  output logic        m_axis_tlast   // case_done
);
  import dsc_pkg::*;

  back_status_t status;
  logic         f_valid;
  logic         f_ready;
  cmd_t         f_cmd;
  logic         q_valid;
  logic         q_ready;
  cmd_t         q_cmd;

  dsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .status        (status),
    .cmd_valid     (f_valid),
    .cmd_ready     (f_ready),
    .cmd           (f_cmd)
  );

  dsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  dsc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .status        (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: sv/dsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks of the divisible subarray counter.
// ----------------------------------------------------------------------------
module dsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic [16:0] cfg_wr_data,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // The store sweep after reset holds off input.
  a_no_input_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input ready right after reset");

  a_no_output_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_pair_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[24:0] < 25'd20091101))
    else $error("pair count not reduced");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[47:42] == 6'd0))
    else $error("result padding not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind divisible_subarray_counter dsc_checker u_chk (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams cases of values into the divisible subarray counter and checks each
// running pair count, disjoint count and case flag against a software model
// of the residue stores. A directed table comes first, then random cases over
// many divisor settings, then one longer case under divisor one.
// ----------------------------------------------------------------------------
module testbench;
  import dsc_pkg::*;

  localparam int STALL_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 600;
  localparam int RANDOM_ITEMS = 1300;
  // Enough case starts to run the store tags out once mid-run.
  localparam int MIN_STARTS   = 270;
  localparam int LONG_CASE    = 64;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 200;
  localparam int DIR_ROWS     = 19;

  typedef enum {RX_OPEN, RX_THIRD, RX_COIN, RX_MOSTLY} rx_pattern_t;

  typedef struct packed {
    logic [PAIR_W-1:0] pairs;
    logic [BEST_W-1:0] best;
    logic              done;
  } count_result_t;

  typedef struct packed {
    bit                 set_div;
    bit [DIV_W-1:0]     div;
    bit                 start;
    bit [VALUE_W-1:0]   value;
    bit                 last;
    bit                 typed;
    bit [PAIR_W-1:0]    pairs;
    bit [BEST_W-1:0]    best;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [16:0] cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  divisible_subarray_counter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Software copy of the residue stores. An entry is live only when its tag
  // matches the current case number, so a case start costs nothing.
  bit [BEST_W-1:0]  res_count [0:65535];
  bit [BEST_W-1:0]  res_best [0:65535];
  int unsigned      res_tag [0:65535];
  int unsigned      case_gen = 1;
  bit [DIV_W-1:0]   divisor_shadow = DIV_W'(1);
  bit [RES_W-1:0]   run_residue;
  bit [PAIR_W-1:0]  pair_total;
  bit [BEST_W-1:0]  best_total;

  count_result_t    expected_counts[$];
  int               mismatch_count;
  int               results_checked;
  int               items_sent;
  int               case_starts;
  int               divisor_writes;
  int               burst_left;
  bit               long_hold_pending;

  directed_row_t dir_rows [0:DIR_ROWS-1] = '{
    // After reset the stores are empty, so the first residue is unseen.
    '{1'b0, 17'd0,      1'b0, 20'h00000, 1'b0, 1'b1, 25'd0, 17'd0},
    '{1'b0, 17'd0,      1'b0, 20'hFFFFF, 1'b1, 1'b1, 25'd1, 17'd1},
    '{1'b0, 17'd0,      1'b1, 20'h00007, 1'b0, 1'b1, 25'd1, 17'd1},
    // A zero divisor behaves as one.
    '{1'b1, 17'd0,      1'b1, 20'h00003, 1'b1, 1'b1, 25'd1, 17'd1},
    // No start after an end: the case carries on.
    '{1'b0, 17'd0,      1'b0, 20'h00009, 1'b0, 1'b1, 25'd3, 17'd2},
    '{1'b1, 17'd65536,  1'b1, 20'hFFFFF, 1'b0, 1'b1, 25'd0, 17'd0},
    '{1'b0, 17'd0,      1'b0, 20'h00001, 1'b0, 1'b1, 25'd1, 17'd1},
    // Divisors above the table size clamp to it, even mid case.
    '{1'b1, 17'd131071, 1'b0, 20'h10000, 1'b0, 1'b1, 25'd3, 17'd2},
    '{1'b1, 17'd7,      1'b0, 20'd10,    1'b1, 1'b1, 25'd3, 17'd2},
    '{1'b1, 17'd65537,  1'b1, 20'h10000, 1'b0, 1'b1, 25'd1, 17'd1},
    '{1'b1, 17'd3,      1'b1, 20'd1,     1'b0, 1'b0, 25'd0, 17'd0},
    '{1'b0, 17'd0,      1'b0, 20'd2,     1'b0, 1'b0, 25'd0, 17'd0},
    '{1'b0, 17'd0,      1'b0, 20'd3,     1'b0, 1'b0, 25'd0, 17'd0},
    '{1'b0, 17'd0,      1'b0, 20'd0,     1'b0, 1'b0, 25'd0, 17'd0},
    '{1'b0, 17'd0,      1'b0, 20'd5,     1'b1, 1'b0, 25'd0, 17'd0},
    '{1'b1, 17'd2,      1'b1, 20'hFFFFF, 1'b0, 1'b0, 25'd0, 17'd0},
    '{1'b0, 17'd0,      1'b0, 20'hFFFFF, 1'b0, 1'b0, 25'd0, 17'd0},
    '{1'b0, 17'd0,      1'b0, 20'hAAAAA, 1'b0, 1'b0, 25'd0, 17'd0},
    '{1'b0, 17'd0,      1'b0, 20'h55555, 1'b1, 1'b0, 25'd0, 17'd0}
  };

  function automatic int unsigned active_divisor();
    int unsigned k;
    k = 32'(divisor_shadow);
    if (k == 0) begin
      k = 1;
    end else if (k > 32'(MAX_K)) begin
      k = 32'(MAX_K);
    end
    return k;
  endfunction

  function automatic count_result_t predict_counts(input bit start, input bit [VALUE_W-1:0] v,
                                                   input bit last);
    int unsigned   r;
    int unsigned   sum;
    bit            live;
    bit [BEST_W-1:0] cnt;
    bit [BEST_W-1:0] bst;
    bit [BEST_W-1:0] cand;
    count_result_t res;
    if (start) begin
      case_gen++;
      run_residue = '0;
      pair_total  = '0;
      best_total  = '0;
      res_tag[0]   = case_gen;
      res_count[0] = BEST_W'(1);
      res_best[0]  = '0;
    end
    r    = (int'(run_residue) + int'(v)) % active_divisor();
    live = (res_tag[r] == case_gen);
    cnt  = live ? res_count[r] : '0;
    bst  = live ? res_best[r] : '0;
    sum  = (int'(pair_total) + int'(cnt)) % int'(PAIR_MOD);
    pair_total = PAIR_W'(sum);
    if (cnt != SAT17) begin
      cnt++;
    end
    if (live) begin
      cand = (bst != SAT17) ? bst + 1'b1 : bst;
      if (cand > best_total) begin
        best_total = cand;
      end
    end
    res_count[r] = cnt;
    res_best[r]  = best_total;
    res_tag[r]   = case_gen;
    run_residue  = RES_W'(r);
    res.pairs = pair_total;
    res.best  = best_total;
    res.done  = last;
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sender pacing: bursts of back-to-back items with idle gaps in between.
  task automatic pace_sender();
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic push_box(input bit start, input bit [VALUE_W-1:0] v, input bit last,
                          input bit typed, input count_result_t want);
    count_result_t pred;
    pace_sender();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, v};
    s_axis_tuser  <= start;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    pred = predict_counts(start, v, last);
    expected_counts.push_back(typed ? want : pred);
    items_sent++;
    if (start) begin
      case_starts++;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  task automatic write_divisor(input bit [DIV_W-1:0] k);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    divisor_shadow = k;
    divisor_writes++;
  endtask

  function automatic bit [DIV_W-1:0] pick_divisor();
    int sel;
    sel = $urandom_range(0, 11);
    case (sel)
      0: return '0;
      1: return DIV_W'(1);
      2: return MAX_K;
      3: return SAT17;
      4: return DIV_W'($urandom_range(65537, 131070));
      5, 6: return DIV_W'($urandom_range(1, 65536));
      default: return DIV_W'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic bit [VALUE_W-1:0] pick_value();
    int unsigned k;
    int sel;
    k   = active_divisor();
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: return VALUE_W'($urandom_range(0, 20'hFFFFF));
      4, 5: return VALUE_W'($urandom_range(0, k));
      6: return '0;
      7: return VALUE_W'(k * $urandom_range(0, 15));
      8: return VALUE_W'(20'hFFFFF - $urandom_range(0, 3));
      default: return VALUE_W'(1 << $urandom_range(0, VALUE_W - 1));
    endcase
  endfunction

  // Mostly well-formed cases; a few lose their start or end flag, and stray
  // flags land inside a case now and then.
  task automatic run_case();
    int len;
    int sel;
    bit start;
    bit last;
    sel = $urandom_range(0, 19);
    if (sel < 16) begin
      len = $urandom_range(1, 3);
    end else if (sel < 19) begin
      len = $urandom_range(4, 16);
    end else begin
      len = $urandom_range(17, 40);
    end
    for (int i = 0; i < len; i++) begin
      start = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
      last  = (i == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
      push_box(start, pick_value(), last, 1'b0, '0);
    end
  endtask

  // Receiver: switches between random stall patterns, each held for a random span,
  // and holds off for a long stretch once when asked.
  initial begin
    rx_pattern_t rx_mode;
    int          rx_span;
    int          rx_phase;
    m_axis_tready = 1'b0;
    rx_mode  = RX_OPEN;
    rx_span  = 0;
    rx_phase = 0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_span == 0) begin
        rx_mode = rx_pattern_t'($urandom_range(0, 3));
        rx_span = $urandom_range(20, 300);
      end
      rx_span--;
      rx_phase++;
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_THIRD:  m_axis_tready <= (rx_phase % 3 == 0);
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        default:   m_axis_tready <= (rx_phase % 8 != 7);
      endcase
    end
  end

  // Result checker: every output transaction is matched against the oldest
  // pending expectation.
  always @(posedge clk) begin
    count_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (expected_counts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result with nothing pending, got pair_count %0d max_disjoint %0d",
                   $time, m_axis_tdata[24:0], m_axis_tdata[41:25]);
        end
      end else begin
        want = expected_counts.pop_front();
        if (m_axis_tdata[24:0] !== want.pairs) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: pair_count mismatch, expected %0d, got %0d",
                     $time, want.pairs, m_axis_tdata[24:0]);
          end
        end
        if (m_axis_tdata[41:25] !== want.best) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: max_disjoint mismatch, expected %0d, got %0d",
                     $time, want.best, m_axis_tdata[41:25]);
          end
        end
        if (m_axis_tlast !== want.done) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: case_done mismatch, expected %0d, got %0d",
                     $time, want.done, m_axis_tlast);
          end
        end
      end
    end
  end

  // Watchdog: the reset sweep of the residue store is the longest quiet
  // stretch a correct block shows; the limit is a few times that.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no transaction for %0d cycles, %0d results still pending",
             $time, STALL_LIMIT, expected_counts.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    count_result_t want;
    int            rand_items;
    int            first_start;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = 1'b0;
    long_hold_pending = 1'b0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].set_div) begin
        write_divisor(dir_rows[i].div);
      end
      want.pairs = dir_rows[i].pairs;
      want.best  = dir_rows[i].best;
      want.done  = dir_rows[i].last;
      push_box(dir_rows[i].start, dir_rows[i].value, dir_rows[i].last,
               dir_rows[i].typed, want);
    end

    // Random phases, each under one divisor. The first phase opens with the
    // long receiver hold while the sender keeps offering.
    first_start = items_sent;
    while ((items_sent - first_start) < RANDOM_ITEMS || case_starts < MIN_STARTS) begin
      write_divisor(pick_divisor());
      if (!long_hold_pending && divisor_writes == 8) begin
        long_hold_pending = 1'b1;
        burst_left = 60;
      end
      repeat ($urandom_range(5, 25)) run_case();
    end
    rand_items = items_sent - first_start;

    // One longer case with divisor one, so every prefix collides.
    write_divisor(DIV_W'(1));
    for (int i = 0; i < LONG_CASE; i++) begin
      push_box(i == 0, pick_value(), i == LONG_CASE - 1, 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d random) in %0d cases over %0d divisor writes.",
             items_sent, rand_items, case_starts, divisor_writes);
    $display("Checked %0d results, ending with a %0d-item case under divisor one.",
             results_checked, LONG_CASE);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/dsc_pkg.sv
sv/dsc_front.sv
sv/dsc_queue.sv
sv/dsc_divider.sv
sv/dsc_back.sv
sv/divisible_subarray_counter.sv
sv/dsc_checker.sv
tb/sv/testbench.sv
